@@ rtl/sdc_pkg.sv @@
`timescale 1ns / 1ps

package sdc_pkg;

    localparam int STEP_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RECORD_SHIFT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_MASK = 1'd1;

    localparam logic [1:0] RESET_RECORD_SHIFT = 2'd2;
    localparam logic [2:0] RESET_RECORD_MASK = 3'd3;

    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [1:0] WT_NORMAL = 2'd0;
    localparam logic [1:0] WT_DIRECTORY = 2'd1;
    localparam logic [1:0] WT_UNALLOC = 2'd2;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_COPY = 2'd2;
    localparam logic [1:0] ACT_FINISH = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  write_type;
        logic [3:0]  disk;
        logic [15:0] track;
        logic [7:0]  record;
        logic        disk_error;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  cmd_disk;
        logic [15:0] cmd_track;
        logic [7:0]  cmd_sector;
        logic [2:0]  record_offset;
        logic        failed;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WRITEBACK,
        PH_PREREAD,
        PH_FLUSH
    } t_phase;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_CPL,
        C_PH0,
        C_PH1,
        C_PH2,
        C_FLUSH,
        C_DIRTY,
        C_HIT,
        C_PRE,
        C_ERR,
        C_DIRWR
    } t_cond;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_WB,
        EM_READ,
        EM_COPY,
        EM_FIN_OK,
        EM_FIN_ERR
    } t_emit;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSTALL,
        OP_DIRTY_IF_WR,
        OP_CLR_DIRTY,
        OP_INVALIDATE
    } t_op;

    typedef struct packed {
        t_cond             cond;
        logic              inv;
        logic [STEP_W-1:0] target;
        t_emit             emit;
        t_op               op;
        logic              phase_we;
        t_phase            phase;
        logic              last;
        logic              done;
    } t_uop;

    localparam logic [STEP_W-1:0] L_INSTALL = 5'd5;
    localparam logic [STEP_W-1:0] L_COPY = 5'd7;
    localparam logic [STEP_W-1:0] L_DIR_WB = 5'd9;
    localparam logic [STEP_W-1:0] L_MISS_WB = 5'd10;
    localparam logic [STEP_W-1:0] L_FLUSH = 5'd11;
    localparam logic [STEP_W-1:0] L_CPL = 5'd13;
    localparam logic [STEP_W-1:0] L_FIN_ERR = 5'd16;
    localparam logic [STEP_W-1:0] L_CPL_WB = 5'd17;
    localparam logic [STEP_W-1:0] L_CPL_RD = 5'd19;
    localparam logic [STEP_W-1:0] L_END = 5'd21;

    function automatic t_uop mk(
        input t_cond             cond,
        input logic              inv,
        input logic [STEP_W-1:0] target,
        input t_emit             emit,
        input t_op               op,
        input logic              phase_we,
        input t_phase            phase,
        input logic              last,
        input logic              done
    );
        t_uop u;
        u.cond = cond;
        u.inv = inv;
        u.target = target;
        u.emit = emit;
        u.op = op;
        u.phase_we = phase_we;
        u.phase = phase;
        u.last = last;
        u.done = done;
        return u;
    endfunction

    function automatic t_uop uop_rom(input logic [STEP_W-1:0] addr);
        t_uop u;
        case (addr)
            5'd0:  u = mk(C_CPL, 1'b0, L_CPL, EM_NONE, OP_NONE, 1'b0, PH_IDLE, 1'b0, 1'b0);
            5'd1:  u = mk(C_PH0, 1'b1, L_END, EM_NONE, OP_NONE, 1'b0, PH_IDLE, 1'b0, 1'b0);
            5'd2:  u = mk(C_FLUSH, 1'b0, L_FLUSH, EM_NONE, OP_NONE, 1'b0, PH_IDLE, 1'b0, 1'b0);
            5'd3:  u = mk(C_HIT, 1'b0, L_COPY, EM_NONE, OP_NONE, 1'b0, PH_IDLE, 1'b0, 1'b0);
            5'd4:  u = mk(C_DIRTY, 1'b0, L_MISS_WB, EM_NONE, OP_NONE, 1'b0, PH_IDLE,
                          1'b0, 1'b0);
            5'd5:  u = mk(C_PRE, 1'b1, L_COPY, EM_NONE, OP_INSTALL, 1'b0, PH_IDLE,
                          1'b0, 1'b0);
            5'd6:  u = mk(C_NONE, 1'b0, L_END, EM_READ, OP_NONE, 1'b1, PH_PREREAD,
                          1'b1, 1'b1);
            5'd7:  u = mk(C_DIRWR, 1'b0, L_DIR_WB, EM_COPY, OP_DIRTY_IF_WR, 1'b0, PH_IDLE,
                          1'b0, 1'b0);
            5'd8:  u = mk(C_NONE, 1'b0, L_END, EM_FIN_OK, OP_NONE, 1'b1, PH_IDLE,
                          1'b1, 1'b1);
            5'd9:  u = mk(C_NONE, 1'b0, L_END, EM_WB, OP_CLR_DIRTY, 1'b1, PH_FLUSH,
                          1'b1, 1'b1);
            5'd10: u = mk(C_NONE, 1'b0, L_END, EM_WB, OP_CLR_DIRTY, 1'b1, PH_WRITEBACK,
                          1'b1, 1'b1);
            5'd11: u = mk(C_DIRTY, 1'b0, L_DIR_WB, EM_NONE, OP_NONE, 1'b0, PH_IDLE,
                          1'b0, 1'b0);
            5'd12: u = mk(C_NONE, 1'b0, L_END, EM_FIN_OK, OP_NONE, 1'b1, PH_IDLE,
                          1'b1, 1'b1);
            5'd13: u = mk(C_PH1, 1'b0, L_CPL_WB, EM_NONE, OP_NONE, 1'b0, PH_IDLE,
                          1'b0, 1'b0);
            5'd14: u = mk(C_PH2, 1'b0, L_CPL_RD, EM_NONE, OP_NONE, 1'b0, PH_IDLE,
                          1'b0, 1'b0);
            5'd15: u = mk(C_PH0, 1'b0, L_END, EM_NONE, OP_NONE, 1'b0, PH_IDLE, 1'b0, 1'b0);
            5'd16: u = mk(C_NONE, 1'b0, L_END, EM_FIN_ERR, OP_NONE, 1'b1, PH_IDLE,
                          1'b1, 1'b1);
            5'd17: u = mk(C_ERR, 1'b0, L_FIN_ERR, EM_NONE, OP_NONE, 1'b0, PH_IDLE,
                          1'b0, 1'b0);
            5'd18: u = mk(C_ALWAYS, 1'b0, L_INSTALL, EM_NONE, OP_NONE, 1'b0, PH_IDLE,
                          1'b0, 1'b0);
            5'd19: u = mk(C_ERR, 1'b1, L_COPY, EM_NONE, OP_NONE, 1'b0, PH_IDLE, 1'b0, 1'b0);
            5'd20: u = mk(C_NONE, 1'b0, L_END, EM_FIN_ERR, OP_INVALIDATE, 1'b1, PH_IDLE,
                          1'b1, 1'b1);
            default: u = mk(C_NONE, 1'b0, L_END, EM_NONE, OP_NONE, 1'b0, PH_IDLE,
                            1'b0, 1'b1);
        endcase
        return u;
    endfunction

endpackage

@@ rtl/sector_deblock_controller.sv @@
`timescale 1ns / 1ps

// Channel    Direction  Handshake                 Payload
// in         to block   i_in_valid / o_in_stall   i_in_data  (t_in_item)
// out        from block o_out_valid / i_out_stall o_out_data (t_out_item)
// cfg        to block   i_cfg_we                  i_cfg_index, i_cfg_data
//
// An item is accepted and then runs three to eight steps of the microcode program,
// one step a cycle except where a step waits for the output register.
// A step that produces a beat waits while the output register is full and stalled.
// Reset is synchronous and active low; it empties the buffer and the output register.
// o_in_stall is high from acceptance until the program for that item ends.

module sector_deblock_controller
    import sdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [1:0]        r_record_shift;
    logic [2:0]        r_record_mask;

    logic              r_run;
    logic [STEP_W-1:0] r_step;
    logic [1:0]        r_kind;
    logic              r_err;

    logic              r_valid;
    logic              r_dirty;
    logic [3:0]        r_buf_disk;
    logic [15:0]       r_buf_track;
    logic [7:0]        r_buf_sector;

    logic [3:0]        r_run_count;
    logic [3:0]        r_run_disk;
    logic [15:0]       r_run_track;
    logic [7:0]        r_run_record;

    t_phase            r_phase;
    logic [1:0]        r_pend_kind;
    logic              r_pend_pre;
    logic              r_pend_dir;
    logic [2:0]        r_pend_offset;
    logic [3:0]        r_pend_disk;
    logic [15:0]       r_pend_track;
    logic [7:0]        r_pend_sector;

    logic              r_out_valid;
    t_out_item         r_out;

    logic              n_run;
    logic [STEP_W-1:0] n_step;
    logic              n_out_valid;
    t_out_item         n_out;

    t_uop              uop;
    logic              cond_val;
    logic              fire;
    logic              in_acc;
    logic              take_req;

    logic              run_load;
    logic [3:0]        run_cnt0;
    logic [3:0]        run_disk0;
    logic [15:0]       run_track0;
    logic [7:0]        run_rec0;
    logic              run_match;
    logic [3:0]        n_run_count;
    logic [7:0]        n_run_record;
    logic              n_pend_pre;

    assign o_in_stall = r_run;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    assign in_acc = i_in_valid && !r_run;
    assign take_req = in_acc && i_in_data.kind != KIND_DONE && r_phase == PH_IDLE;

    assign uop = uop_rom(r_step);

    always_comb begin
        case (uop.cond)
            C_NONE:   cond_val = 1'b0;
            C_ALWAYS: cond_val = 1'b1;
            C_CPL:    cond_val = r_kind == KIND_DONE;
            C_PH0:    cond_val = r_phase == PH_IDLE;
            C_PH1:    cond_val = r_phase == PH_WRITEBACK;
            C_PH2:    cond_val = r_phase == PH_PREREAD;
            C_FLUSH:  cond_val = r_kind == KIND_FLUSH;
            C_DIRTY:  cond_val = r_dirty;
            C_HIT:    cond_val = r_valid && r_buf_disk == r_pend_disk
                                 && r_buf_track == r_pend_track
                                 && r_buf_sector == r_pend_sector;
            C_PRE:    cond_val = r_pend_pre;
            C_ERR:    cond_val = r_err;
            C_DIRWR:  cond_val = r_pend_kind == KIND_WRITE && r_pend_dir;
            default:  cond_val = 1'b0;
        endcase
    end

    assign fire = r_run && (uop.emit == EM_NONE || !r_out_valid || !i_out_stall);

    always_comb begin
        n_run = r_run;
        n_step = r_step;
        if (in_acc) begin
            n_run = 1'b1;
            n_step = '0;
        end else if (fire) begin
            n_step = (cond_val ^ uop.inv) ? uop.target : r_step + 1'b1;
            if (uop.done) begin
                n_run = 1'b0;
            end
        end
    end

    always_comb begin
        n_out = '0;
        n_out.last = uop.last;
        case (uop.emit)
            EM_WB: begin
                n_out.action = ACT_WRITE;
                n_out.cmd_disk = r_buf_disk;
                n_out.cmd_track = r_buf_track;
                n_out.cmd_sector = r_buf_sector;
            end
            EM_READ: begin
                n_out.action = ACT_READ;
                n_out.cmd_disk = r_buf_disk;
                n_out.cmd_track = r_buf_track;
                n_out.cmd_sector = r_buf_sector;
            end
            EM_COPY: begin
                n_out.action = ACT_COPY;
                n_out.record_offset = r_pend_offset;
            end
            EM_FIN_OK: begin
                n_out.action = ACT_FINISH;
            end
            EM_FIN_ERR: begin
                n_out.action = ACT_FINISH;
                n_out.failed = r_err;
            end
            default: begin
                n_out = '0;
            end
        endcase
        n_out_valid = r_out_valid && i_out_stall;
        if (fire && uop.emit != EM_NONE) begin
            n_out_valid = 1'b1;
        end
    end

    always_comb begin
        run_load = i_in_data.kind == KIND_WRITE && i_in_data.write_type == WT_UNALLOC;
        run_cnt0 = run_load ? {1'b0, r_record_mask} + 4'd1 : r_run_count;
        run_disk0 = run_load ? i_in_data.disk : r_run_disk;
        run_track0 = run_load ? i_in_data.track : r_run_track;
        run_rec0 = run_load ? i_in_data.record : r_run_record;
        run_match = i_in_data.disk == run_disk0 && i_in_data.track == run_track0
                    && i_in_data.record == run_rec0;
        n_run_count = run_cnt0;
        n_run_record = run_rec0;
        n_pend_pre = 1'b1;
        if (i_in_data.kind == KIND_WRITE && run_cnt0 != 4'd0) begin
            if (run_match) begin
                n_run_count = run_cnt0 - 4'd1;
                n_run_record = run_rec0 + 8'd1;
                n_pend_pre = 1'b0;
            end else begin
                n_run_count = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_shift <= RESET_RECORD_SHIFT;
            r_record_mask <= RESET_RECORD_MASK;
            r_run <= 1'b0;
            r_step <= '0;
            r_out_valid <= 1'b0;
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_run_count <= 4'd0;
            r_phase <= PH_IDLE;
            r_pend_kind <= KIND_READ;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RECORD_SHIFT: r_record_shift <= i_cfg_data[1:0];
                    REG_RECORD_MASK:  r_record_mask <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_run <= n_run;
            r_step <= n_step;
            r_out_valid <= n_out_valid;
            if (take_req) begin
                r_pend_kind <= i_in_data.kind;
                if (i_in_data.kind == KIND_WRITE) begin
                    r_run_count <= n_run_count;
                end
            end
            if (fire) begin
                if (uop.phase_we) begin
                    r_phase <= uop.phase;
                end
                case (uop.op)
                    OP_INSTALL: begin
                        r_valid <= 1'b1;
                        r_dirty <= 1'b0;
                    end
                    OP_DIRTY_IF_WR: begin
                        if (r_pend_kind == KIND_WRITE) begin
                            r_dirty <= 1'b1;
                        end
                    end
                    OP_CLR_DIRTY:  r_dirty <= 1'b0;
                    OP_INVALIDATE: r_valid <= 1'b0;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_in_data.kind;
            r_err <= i_in_data.disk_error;
        end
        if (take_req && i_in_data.kind != KIND_FLUSH) begin
            r_pend_disk <= i_in_data.disk;
            r_pend_track <= i_in_data.track;
            r_pend_sector <= i_in_data.record >> r_record_shift;
            r_pend_offset <= i_in_data.record[2:0] & r_record_mask;
            r_pend_pre <= n_pend_pre;
            r_pend_dir <= i_in_data.kind == KIND_WRITE && i_in_data.write_type == WT_DIRECTORY;
            if (i_in_data.kind == KIND_WRITE) begin
                r_run_disk <= run_disk0;
                r_run_track <= run_track0;
                r_run_record <= n_run_record;
            end
        end
        if (fire && uop.op == OP_INSTALL) begin
            r_buf_disk <= r_pend_disk;
            r_buf_track <= r_pend_track;
            r_buf_sector <= r_pend_sector;
        end
        if (fire && uop.emit != EM_NONE) begin
            r_out <= n_out;
        end
    end

    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dirty |-> r_valid)
        else $error("dirty buffer without valid contents");

    a_preread_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PREREAD |-> r_valid)
        else $error("pre-read pending on an invalid buffer");

    a_copy_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.action == ACT_COPY |-> !r_out.last)
        else $error("copy beat marked as last");

    a_start_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_run && r_step == '0)
        else $error("program did not start at step zero");

endmodule

@@ test/sdc_deblock_checker.sv @@
`timescale 1ns / 1ps

module sdc_deblock_checker
    import sdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_phase                o_phase,
    output int                    o_outstanding,
    output int                    o_errors
);

    logic [1:0]  rec_shift;
    logic [2:0]  rec_mask;

    logic        buf_valid;
    logic        buf_dirty;
    logic [3:0]  buf_disk;
    logic [15:0] buf_track;
    logic [7:0]  buf_sector;

    logic [3:0]  run_left;
    logic [3:0]  run_disk;
    logic [15:0] run_track;
    logic [7:0]  run_rec;

    t_phase      phase;
    logic [1:0]  req_kind;
    logic        req_preread;
    logic        req_dir;
    logic [2:0]  req_offset;
    logic [3:0]  req_disk;
    logic [15:0] req_track;
    logic [7:0]  req_sector;

    t_out_item   expected_beats[$];
    int          step_beats;
    int          errors;

    function automatic string beat_text(input t_out_item b);
        return $sformatf("act=%0d disk=%0d track=%h sector=%0d off=%0d fail=%0b last=%0b",
                         b.action, b.cmd_disk, b.cmd_track, b.cmd_sector,
                         b.record_offset, b.failed, b.last);
    endfunction

    task automatic reset_model();
        rec_shift = RESET_RECORD_SHIFT;
        rec_mask = RESET_RECORD_MASK;
        buf_valid = 1'b0;
        buf_dirty = 1'b0;
        buf_disk = '0;
        buf_track = '0;
        buf_sector = '0;
        run_left = '0;
        run_disk = '0;
        run_track = '0;
        run_rec = '0;
        phase = PH_IDLE;
        req_kind = KIND_READ;
        req_preread = 1'b0;
        req_dir = 1'b0;
        req_offset = '0;
        req_disk = '0;
        req_track = '0;
        req_sector = '0;
        expected_beats.delete();
    endtask

    task automatic push_beat(input logic [1:0] act, input logic [3:0] d, input logic [15:0] t,
                             input logic [7:0] s, input logic [2:0] off, input logic fail);
        t_out_item b;
        b.action = act;
        b.cmd_disk = d;
        b.cmd_track = t;
        b.cmd_sector = s;
        b.record_offset = off;
        b.failed = fail;
        b.last = 1'b0;
        expected_beats.push_back(b);
        step_beats++;
    endtask

    task automatic push_writeback();
        buf_dirty = 1'b0;
        push_beat(ACT_WRITE, buf_disk, buf_track, buf_sector, '0, 1'b0);
    endtask

    task automatic copy_and_finish();
        push_beat(ACT_COPY, '0, '0, '0, req_offset, 1'b0);
        if (req_kind == KIND_WRITE) begin
            buf_dirty = 1'b1;
        end
        if (req_kind == KIND_WRITE && req_dir) begin
            phase = PH_FLUSH;
            push_writeback();
        end else begin
            phase = PH_IDLE;
            push_beat(ACT_FINISH, '0, '0, '0, '0, 1'b0);
        end
    endtask

    task automatic install_sector();
        buf_disk = req_disk;
        buf_track = req_track;
        buf_sector = req_sector;
        buf_valid = 1'b1;
        buf_dirty = 1'b0;
        if (req_preread) begin
            phase = PH_PREREAD;
            push_beat(ACT_READ, buf_disk, buf_track, buf_sector, '0, 1'b0);
        end else begin
            copy_and_finish();
        end
    endtask

    task automatic begin_access();
        if (buf_valid && buf_disk == req_disk && buf_track == req_track
                && buf_sector == req_sector) begin
            copy_and_finish();
        end else if (buf_dirty) begin
            phase = PH_WRITEBACK;
            push_writeback();
        end else begin
            install_sector();
        end
    endtask

    task automatic deblock_step(input t_in_item it);
        t_out_item b;
        step_beats = 0;
        if (it.kind == KIND_DONE) begin
            case (phase)
                PH_WRITEBACK: begin
                    if (it.disk_error) begin
                        phase = PH_IDLE;
                        push_beat(ACT_FINISH, '0, '0, '0, '0, 1'b1);
                    end else begin
                        install_sector();
                    end
                end
                PH_PREREAD: begin
                    if (it.disk_error) begin
                        buf_valid = 1'b0;
                        phase = PH_IDLE;
                        push_beat(ACT_FINISH, '0, '0, '0, '0, 1'b1);
                    end else begin
                        copy_and_finish();
                    end
                end
                PH_FLUSH: begin
                    phase = PH_IDLE;
                    push_beat(ACT_FINISH, '0, '0, '0, '0, it.disk_error);
                end
                default: ;
            endcase
        end else if (phase == PH_IDLE) begin
            req_kind = it.kind;
            if (it.kind == KIND_FLUSH) begin
                if (buf_dirty) begin
                    phase = PH_FLUSH;
                    push_writeback();
                end else begin
                    push_beat(ACT_FINISH, '0, '0, '0, '0, 1'b0);
                end
            end else begin
                req_disk = it.disk;
                req_track = it.track;
                req_sector = it.record >> rec_shift;
                req_offset = it.record[2:0] & rec_mask;
                req_preread = 1'b1;
                req_dir = 1'b0;
                if (it.kind == KIND_WRITE) begin
                    req_dir = (it.write_type == WT_DIRECTORY);
                    if (it.write_type == WT_UNALLOC) begin
                        run_left = {1'b0, rec_mask} + 4'd1;
                        run_disk = it.disk;
                        run_track = it.track;
                        run_rec = it.record;
                    end
                    if (run_left != '0) begin
                        if (it.disk == run_disk && it.track == run_track
                                && it.record == run_rec) begin
                            run_left = run_left - 4'd1;
                            run_rec = run_rec + 8'd1;
                            req_preread = 1'b0;
                        end else begin
                            run_left = '0;
                        end
                    end
                end
                begin_access();
            end
        end
        if (step_beats > 0) begin
            b = expected_beats.pop_back();
            b.last = 1'b1;
            expected_beats.push_back(b);
        end
    endtask

    task automatic check_beat(input t_out_item got);
        t_out_item want;
        if (expected_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, got %s", $time, beat_text(got));
        end else begin
            want = expected_beats.pop_front();
            if (got.action !== want.action || got.cmd_disk !== want.cmd_disk
                    || got.cmd_track !== want.cmd_track || got.cmd_sector !== want.cmd_sector
                    || got.record_offset !== want.record_offset
                    || got.failed !== want.failed || got.last !== want.last) begin
                errors++;
                $display("%0t: beat mismatch, expected %s, got %s", $time,
                         beat_text(want), beat_text(got));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RECORD_SHIFT: rec_shift = i_cfg_data[1:0];
                    REG_RECORD_MASK:  rec_mask = i_cfg_data;
                    default: ;
                endcase
            end
            // A result leaving now always belongs to an item accepted earlier.
            if (i_out_valid && !i_out_stall) begin
                check_beat(i_out_data);
            end
            if (i_in_valid && !i_in_stall) begin
                deblock_step(i_in_data);
            end
        end
        o_phase <= phase;
        o_outstanding <= expected_beats.size();
        o_errors <= errors;
    end

endmodule

@@ test/tb_sector_deblock_controller.sv @@
`timescale 1ns / 1ps

module tb_sector_deblock_controller;
    import sdc_pkg::*;

    localparam logic [1:0] WT_UNKNOWN = 2'd3;
    localparam int PHASE_COUNT = 6;
    localparam int ITEMS_PER_PHASE = 250;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_phase                chk_phase;
    int                    chk_outstanding;
    int                    chk_errors;

    t_stall_mode           stall_mode = STALL_NONE;
    int                    stall_hold = 0;
    int                    stall_tick = 0;

    logic [3:0]            hot_disk = '0;
    logic [15:0]           hot_track = '0;
    logic [7:0]            hot_rec = '0;
    logic [3:0]            seq_disk = '0;
    logic [15:0]           seq_track = '0;
    logic [7:0]            seq_rec = '0;

    logic [1:0]            shift_set [PHASE_COUNT] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
    logic [2:0]            mask_set [PHASE_COUNT] = '{3'd0, 3'd7, 3'd1, 3'd3, 3'd7, 3'd0};

    sector_deblock_controller u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sdc_deblock_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_phase       (chk_phase),
        .o_outstanding (chk_outstanding),
        .o_errors      (chk_errors)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_hold == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_hold <= $urandom_range(20, 300);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input t_in_item it);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic directed_item(input logic [1:0] kind, input logic [1:0] wt,
                                 input logic [3:0] d, input logic [15:0] t,
                                 input logic [7:0] r, input logic err);
        t_in_item it;
        it.kind = kind;
        it.write_type = wt;
        it.disk = d;
        it.track = t;
        it.record = r;
        it.disk_error = err;
        @(posedge clk);
        send_beat(it);
    endtask

    task automatic pick_item(output t_in_item it, output bit useful);
        int roll;
        int aroll;
        roll = $urandom_range(0, 99);
        aroll = $urandom_range(0, 99);
        it.kind = KIND_DONE;
        it.write_type = 2'($urandom_range(0, 3));
        it.disk = 4'($urandom_range(0, 15));
        it.track = 16'($urandom_range(0, 65535));
        it.record = 8'($urandom_range(0, 255));
        it.disk_error = ($urandom_range(0, 4) == 0);
        if ((chk_phase != PH_IDLE && roll < 90) || (chk_phase == PH_IDLE && roll < 5)) begin
            useful = (chk_phase != PH_IDLE);
        end else begin
            useful = (chk_phase == PH_IDLE);
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                it.kind = KIND_READ;
            end else if (roll < 82) begin
                it.kind = KIND_WRITE;
            end else begin
                it.kind = KIND_FLUSH;
            end
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                it.write_type = WT_NORMAL;
            end else if (roll < 65) begin
                it.write_type = WT_DIRECTORY;
            end else if (roll < 90) begin
                it.write_type = WT_UNALLOC;
            end else begin
                it.write_type = WT_UNKNOWN;
            end
            if (aroll < 40) begin
                it.disk = hot_disk;
                it.track = hot_track;
                it.record = hot_rec ^ 8'($urandom_range(0, 7));
            end else if (aroll < 70) begin
                it.disk = seq_disk;
                it.track = seq_track;
                it.record = seq_rec;
            end else begin
                if ($urandom_range(0, 1) == 0) it.track = 16'($urandom_range(0, 3));
                if ($urandom_range(0, 7) == 0) it.track = 16'hFFFF;
                hot_disk = it.disk;
                hot_track = it.track;
                hot_rec = it.record;
            end
            if (useful && it.kind == KIND_WRITE
                    && (it.write_type == WT_UNALLOC || (aroll >= 40 && aroll < 70))) begin
                seq_disk = it.disk;
                seq_track = it.track;
                seq_rec = it.record + 8'd1;
            end
        end
    endtask

    task automatic settle_and_configure(input logic [1:0] shift, input logic [2:0] mask);
        t_in_item it;
        @(posedge clk);
        while (chk_phase != PH_IDLE) begin
            it = '0;
            it.kind = KIND_DONE;
            send_beat(it);
            @(posedge clk);
        end
        while (chk_outstanding != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_RECORD_SHIFT;
        cfg_data <= {1'b0, shift};
        @(posedge clk);
        cfg_index <= REG_RECORD_MASK;
        cfg_data <= mask;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_items(input int quota);
        t_in_item it;
        bit useful;
        int sent;
        int burst_left;
        int gap;
        sent = 0;
        burst_left = 0;
        while (sent < quota) begin
            gap = 0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = $urandom_range(1, 12);
            end
            burst_left--;
            repeat (1 + gap) @(posedge clk);
            if ($urandom_range(0, 199) == 0) begin
                while (chk_outstanding != 0) @(posedge clk);
            end
            pick_item(it, useful);
            send_beat(it);
            if (useful) sent++;
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        directed_item(KIND_DONE, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b0);
        directed_item(KIND_READ, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b0);
        directed_item(KIND_DONE, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b0);
        directed_item(KIND_READ, WT_NORMAL, 4'd0, 16'h0000, 8'd3, 1'b1);
        directed_item(KIND_WRITE, WT_NORMAL, 4'd0, 16'h0000, 8'd1, 1'b0);
        directed_item(KIND_FLUSH, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b0);
        directed_item(KIND_DONE, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b1);
        directed_item(KIND_FLUSH, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b0);
        directed_item(KIND_WRITE, WT_UNKNOWN, 4'd15, 16'hFFFF, 8'd255, 1'b1);
        directed_item(KIND_READ, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b0);
        directed_item(KIND_DONE, WT_NORMAL, 4'd15, 16'hFFFF, 8'd255, 1'b0);
        directed_item(KIND_READ, WT_NORMAL, 4'd15, 16'h0000, 8'd0, 1'b0);
        directed_item(KIND_DONE, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b1);
        directed_item(KIND_READ, WT_NORMAL, 4'd0, 16'h0000, 8'd4, 1'b0);
        directed_item(KIND_DONE, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b1);
        directed_item(KIND_WRITE, WT_UNALLOC, 4'd1, 16'h0002, 8'd8, 1'b0);
        directed_item(KIND_WRITE, WT_NORMAL, 4'd1, 16'h0002, 8'd9, 1'b0);
        directed_item(KIND_WRITE, WT_DIRECTORY, 4'd1, 16'h0002, 8'd10, 1'b0);
        directed_item(KIND_DONE, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b0);
        directed_item(KIND_WRITE, WT_NORMAL, 4'd1, 16'h0002, 8'd12, 1'b0);
        directed_item(KIND_DONE, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b0);
        directed_item(KIND_WRITE, WT_NORMAL, 4'd3, 16'h0005, 8'd0, 1'b0);
        directed_item(KIND_DONE, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b0);
        directed_item(KIND_DONE, WT_NORMAL, 4'd0, 16'h0000, 8'd0, 1'b0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle_and_configure(shift_set[p], mask_set[p]);
            random_items(ITEMS_PER_PHASE);
        end

        @(posedge clk);
        for (int n = 0; n < 5000 && chk_outstanding != 0; n++) @(posedge clk);
        repeat (20) @(posedge clk);
        if (chk_errors == 0 && chk_outstanding == 0) begin
            $display("tb_sector_deblock_controller: done, clean");
        end else begin
            if (chk_outstanding != 0) begin
                $display("%0t: %0d expected beats never arrived", $time, chk_outstanding);
            end
            $display("tb_sector_deblock_controller: done, errors");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_sector_deblock_controller: done, errors");
        $finish;
    end

endmodule
